FILE: design/vlrs_pkg.sv
`default_nettype none

package vlrs_pkg;

   // request modes
   localparam logic [1:0] MODE_PUSH  = 2'd0;
   localparam logic [1:0] MODE_PEEK  = 2'd1;
   localparam logic [1:0] MODE_POP   = 2'd2;
   localparam logic [1:0] MODE_QUERY = 2'd3;

   // response status codes
   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_EMPTY = 2'd1;
   localparam logic [1:0] STAT_FULL  = 2'd2;

   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] data_byte;
      logic [6:0] length;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       last;
      logic       would_be_full;
      logic       is_empty;
   } rsp_type;

endpackage

`default_nettype wire

FILE: design/vlrs_ram.sv
`default_nettype none

module vlrs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: design/variable_length_record_stack.sv
`default_nettype none

// LIFO of variable-length byte records held in a CAPACITY-byte RAM. Each record is
// stored as its bytes followed by a LEN_BYTES trailer carrying its length (LSB first).
// Issue a transaction by raising start while busy is low; every transaction gets its
// results on rsp_item, each flagged by a one-cycle rsp_valid strobe the cycle after it
// is produced, and the final one has last set. The receiver cannot stall: results
// must be taken in the cycle they appear. Push sends one byte per transaction; the
// byte that completes a record (or a zero-length push) keeps busy high while the
// trailer is written through the single RAM write port. Room is checked on the
// first byte; a record that does not fit is refused for every one of its bytes. A
// query, or a peek or pop on an empty stack, is answered from the idle state.
// Otherwise peek and pop read the trailer one byte per cycle, then the record
// streams one byte per cycle out of the RAM, whose read data is registered, and
// the n results come out back to back, n being the number of bytes returned (a
// single final result without a byte when n is zero). Any non-push transaction
// abandons a partly pushed record. No clearing pass: RAM contents are only read
// below the top pointer.
module variable_length_record_stack
   import vlrs_pkg::*;
#(
   parameter int CAPACITY   = 4096,
   parameter int LEN_BYTES  = 4,
   parameter int MAX_RECORD = 64
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output      logic    busy,
   input  wire req_type req_item,
   output      logic    rsp_valid,
   output      rsp_type rsp_item
);

   localparam int AW = $clog2(CAPACITY);      // RAM address
   localparam int PW = $clog2(CAPACITY + 1);  // top pointer, can equal CAPACITY
   localparam int RW = PW + 8;                // room for pointer + length sums
   localparam int SW = 8 * LEN_BYTES;         // trailer value
   localparam int CW = (SW > PW) ? SW : PW;
   localparam int LW = (PW > 7) ? PW : 7;

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_TRAILER = 3'd1;
   localparam logic [2:0] S_RD_TRL  = 3'd2;
   localparam logic [2:0] S_CALC    = 3'd3;
   localparam logic [2:0] S_STREAM  = 3'd4;
   localparam logic [2:0] S_DRAIN   = 3'd5;

   // control state
   logic [2:0]    state_ff, state_in;
   logic [PW-1:0] top_ff, top_in;
   logic [6:0]    count_ff, count_in;      // bytes seen of the record in flight
   logic          rej_ff, rej_in;          // record in flight was refused
   logic [6:0]    rec_len_ff, rec_len_in;
   logic          pend_ff, pend_in;        // RAM read data due this cycle
   logic          rsp_valid_ff, rsp_valid_in;

   // working registers
   logic [6:0]    idx_ff, idx_in;
   logic [PW-1:0] tail_ff, tail_in;        // trailer start address
   logic [6:0]    tlen_ff, tlen_in;        // length written into trailer
   logic          drop_ff, drop_in;
   logic [6:0]    want_ff, want_in;
   logic [SW-1:0] stored_ff, stored_in;
   logic [PW-1:0] base_ff, base_in;
   logic [6:0]    n_ff, n_in;
   logic          pend_last_ff, pend_last_in;
   rsp_type       rsp_ff, rsp_in;

   // RAM port
   logic          ram_we;
   logic [AW-1:0] ram_waddr;
   logic [7:0]    ram_wdata;
   logic [AW-1:0] ram_raddr;
   logic [7:0]    ram_rdata;

   logic          accept;
   logic          room_ok;
   logic [6:0]    eff_len;
   logic [RW-1:0] push_addr;
   logic [RW-1:0] trl_wr_addr;
   logic [RW-1:0] trl_rd_addr;
   logic [RW-1:0] strm_addr;
   logic [PW-1:0] avail;
   logic [PW-1:0] stored_c;
   logic [PW-1:0] base_c;
   logic [6:0]    stored_m;
   logic [6:0]    n_c;

   vlrs_ram #(
      .WIDTH (8),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;

   // record of req length plus trailer fits above top
   assign room_ok = (RW'(top_ff) + RW'(req_item.length) + RW'(LEN_BYTES)) <= RW'(CAPACITY);

   // first byte uses the request length, later ones the latched one
   assign eff_len = (count_ff == 7'd0) ? req_item.length : rec_len_ff;

   assign push_addr   = RW'(top_ff) + RW'(count_ff);
   assign trl_wr_addr = RW'(tail_ff) + RW'(idx_ff);
   assign trl_rd_addr = RW'(top_ff) - RW'(LEN_BYTES) + RW'(idx_ff);
   assign strm_addr   = RW'(base_ff) + RW'(idx_ff);

   // trailer decode: clamp to space below trailer, then to MAX_RECORD
   assign avail    = top_ff - PW'(LEN_BYTES);
   assign stored_c = (CW'(stored_ff) > CW'(avail)) ? avail : PW'(stored_ff);
   assign base_c   = avail - stored_c;
   assign stored_m = (LW'(stored_c) > LW'(MAX_RECORD)) ? 7'(MAX_RECORD) : 7'(stored_c);
   assign n_c      = (want_ff < stored_m) ? want_ff : stored_m;

   always_comb begin
      state_in     = state_ff;
      top_in       = top_ff;
      count_in     = count_ff;
      rej_in       = rej_ff;
      rec_len_in   = rec_len_ff;
      pend_in      = 1'b0;
      rsp_valid_in = 1'b0;
      idx_in       = idx_ff;
      tail_in      = tail_ff;
      tlen_in      = tlen_ff;
      drop_in      = drop_ff;
      want_in      = want_ff;
      stored_in    = stored_ff;
      base_in      = base_ff;
      n_in         = n_ff;
      pend_last_in = pend_last_ff;
      rsp_in       = '0;
      ram_we       = 1'b0;
      ram_waddr    = push_addr[AW-1:0];
      ram_wdata    = req_item.data_byte;
      ram_raddr    = strm_addr[AW-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_valid_in = 1'b1;
               rsp_in.last  = 1'b1;
               rsp_in.status = STAT_OK;
               unique case (req_item.mode) inside
                  MODE_PUSH: begin
                     if (count_ff == 7'd0 && req_item.length == 7'd0) begin
                        // empty record: trailer only
                        if (room_ok) begin
                           state_in = S_TRAILER;
                           idx_in   = 7'd0;
                           tail_in  = top_ff;
                           tlen_in  = 7'd0;
                           top_in   = PW'(RW'(top_ff) + RW'(LEN_BYTES));
                        end else begin
                           rsp_in.status = STAT_FULL;
                        end
                     end else if (count_ff == 7'd0 &&
                                  (req_item.length > 7'(MAX_RECORD) || !room_ok)) begin
                        rsp_in.status = STAT_FULL;
                        if (req_item.length > 7'd1) begin
                           rej_in     = 1'b1;
                           count_in   = 7'd1;
                           rec_len_in = req_item.length;
                        end else begin
                           rec_len_in = 7'd0;
                        end
                     end else if (count_ff != 7'd0 && rej_ff) begin
                        rsp_in.status = STAT_FULL;
                        if (count_ff + 7'd1 >= rec_len_ff) begin
                           count_in   = 7'd0;
                           rej_in     = 1'b0;
                           rec_len_in = 7'd0;
                        end else begin
                           count_in = count_ff + 7'd1;
                        end
                     end else begin
                        // accepted record byte lands above top
                        ram_we = 1'b1;
                        if (count_ff + 7'd1 >= eff_len) begin
                           // record complete: commit and write trailer
                           state_in   = S_TRAILER;
                           idx_in     = 7'd0;
                           tail_in    = PW'(RW'(top_ff) + RW'(eff_len));
                           tlen_in    = eff_len;
                           top_in     = PW'(RW'(top_ff) + RW'(eff_len) + RW'(LEN_BYTES));
                           count_in   = 7'd0;
                           rej_in     = 1'b0;
                           rec_len_in = 7'd0;
                        end else begin
                           count_in   = count_ff + 7'd1;
                           rej_in     = 1'b0;
                           rec_len_in = eff_len;
                        end
                     end
                  end
                  MODE_QUERY: begin
                     count_in             = 7'd0;
                     rej_in               = 1'b0;
                     rec_len_in           = 7'd0;
                     rsp_in.would_be_full = !room_ok;
                     rsp_in.is_empty      = (top_ff == '0);
                  end
                  MODE_PEEK, MODE_POP: begin
                     count_in   = 7'd0;
                     rej_in     = 1'b0;
                     rec_len_in = 7'd0;
                     if (RW'(top_ff) < RW'(LEN_BYTES)) begin
                        rsp_in.status = STAT_EMPTY;
                     end else begin
                        // results come later from the stream
                        rsp_valid_in = 1'b0;
                        state_in     = S_RD_TRL;
                        idx_in       = 7'd0;
                        drop_in      = (req_item.mode == MODE_POP);
                        want_in      = req_item.length;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_TRAILER: begin
            ram_we    = 1'b1;
            ram_waddr = trl_wr_addr[AW-1:0];
            ram_wdata = (idx_ff == 7'd0) ? {1'b0, tlen_ff} : 8'd0;
            if (idx_ff == 7'(LEN_BYTES - 1)) begin
               state_in = S_IDLE;
               idx_in   = 7'd0;
            end else begin
               idx_in = idx_ff + 7'd1;
            end
         end
         S_RD_TRL: begin
            // issue trailer byte idx, capture byte idx-1
            ram_raddr = trl_rd_addr[AW-1:0];
            if (idx_ff != 7'd0) begin
               stored_in[8*(idx_ff-7'd1) +: 8] = ram_rdata;
            end
            if (idx_ff == 7'(LEN_BYTES)) begin
               state_in = S_CALC;
               idx_in   = 7'd0;
            end else begin
               idx_in = idx_ff + 7'd1;
            end
         end
         S_CALC: begin
            if (drop_ff) begin
               top_in = base_c;
            end
            base_in = base_c;
            n_in    = n_c;
            idx_in  = 7'd0;
            if (n_c == 7'd0) begin
               state_in      = S_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_in.status = STAT_OK;
               rsp_in.last   = 1'b1;
            end else begin
               state_in = S_STREAM;
            end
         end
         S_STREAM: begin
            ram_raddr    = strm_addr[AW-1:0];
            pend_in      = 1'b1;
            pend_last_in = (idx_ff == n_ff - 7'd1);
            idx_in       = idx_ff + 7'd1;
            if (idx_ff == n_ff - 7'd1) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // record byte read last cycle goes out now
      if (pend_ff) begin
         rsp_valid_in      = 1'b1;
         rsp_in.status     = STAT_OK;
         rsp_in.out_byte   = ram_rdata;
         rsp_in.byte_valid = 1'b1;
         rsp_in.last       = pend_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         top_ff       <= '0;
         count_ff     <= '0;
         rej_ff       <= 1'b0;
         rec_len_ff   <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         top_ff       <= top_in;
         count_ff     <= count_in;
         rej_ff       <= rej_in;
         rec_len_ff   <= rec_len_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      tail_ff      <= tail_in;
      tlen_ff      <= tlen_in;
      drop_ff      <= drop_in;
      want_ff      <= want_in;
      stored_ff    <= stored_in;
      base_ff      <= base_in;
      n_ff         <= n_in;
      pend_last_ff <= pend_last_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

`default_nettype wire

FILE: design/vlrs_checker.sv
`default_nettype none

module vlrs_checker
   import vlrs_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    start,
   input wire logic    busy,
   input wire req_type req_item,
   input wire logic    rsp_valid,
   input wire rsp_type rsp_item
);

   // a push or query answers with exactly one final result next cycle
   a_single_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_item.mode == MODE_PUSH || req_item.mode == MODE_QUERY))
      |=> (rsp_valid && rsp_item.last && !rsp_item.byte_valid))
      else $error("push/query transaction without a single final result");

   // record bytes only ever carry ok status
   a_byte_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.byte_valid) |-> (rsp_item.status == STAT_OK))
      else $error("record byte with non-ok status");

   // a stream of bytes has no gaps
   a_stream_gapless: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_item.last) |=> rsp_valid)
      else $error("gap inside a result stream");

   // no new transaction while a stream is still going
   a_busy_mid_stream: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_item.last) |-> busy)
      else $error("not busy while results still pending");

endmodule

bind variable_length_record_stack vlrs_checker u_vlrs_checker (.*);

`default_nettype wire

FILE: tb/testbench.sv
`default_nettype none

// Checks the variable-length record stack against a cycle-free predictor kept
// in the testbench. Every transaction accepted on req_item is run through the
// predictor at the edge that accepts it, and the predicted responses are queued.
// Each rsp_valid strobe is checked against the head of that queue.
module testbench;
   import vlrs_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int STORE_BYTES    = 4096;
   localparam int TRAILER_BYTES  = 4;
   localparam int RECORD_MAX     = 64;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int MAX_SHOWN      = 10;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_item = '0;
   logic    rsp_valid;
   rsp_type rsp_item;

   variable_length_record_stack #(
      .CAPACITY   (STORE_BYTES),
      .LEN_BYTES  (TRAILER_BYTES),
      .MAX_RECORD (RECORD_MAX)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Predictor state: the byte store, the committed top, and the record
   // currently being pushed (bytes so far, its length, whether it was refused).
   // ---------------------------------------------------------------------
   logic [7:0]  store_mem [STORE_BYTES];
   int unsigned stack_top;
   int unsigned pending_bytes;
   int unsigned pending_len;
   bit          pending_rejected;

   rsp_type expected_rsps [$];
   int      mismatch_count = 0;
   int      idle_cycles    = 0;
   int      idle_pct       = 0;   // chance in 100 that the sender pauses

   function automatic rsp_type make_rsp(logic [1:0] st, logic [7:0] b, logic v,
                                        logic l, logic f, logic e);
      rsp_type r;
      r.status        = st;
      r.out_byte      = b;
      r.byte_valid    = v;
      r.last          = l;
      r.would_be_full = f;
      r.is_empty      = e;
      return r;
   endfunction

   function automatic req_type make_req(logic [1:0] m, logic [7:0] b, logic [6:0] l);
      req_type r;
      r.mode      = m;
      r.data_byte = b;
      r.length    = l;
      return r;
   endfunction

   // record of len bytes plus its trailer fits above the committed top
   function automatic bit record_fits(int unsigned len);
      return (STORE_BYTES - stack_top) >= len + TRAILER_BYTES;
   endfunction

   function automatic void clear_pending();
      pending_bytes    = 0;
      pending_rejected = 1'b0;
      pending_len      = 0;
   endfunction

   // trailer goes right after the record, LSB first; then the top moves
   function automatic void commit_record(int unsigned len);
      for (int i = 0; i < TRAILER_BYTES; i++) begin
         store_mem[stack_top + len + i] = 8'((len >> (8 * i)) & 8'hFF);
      end
      stack_top += len + TRAILER_BYTES;
      clear_pending();
   endfunction

   function automatic void predict_push(logic [7:0] b, int unsigned len);
      logic [1:0] st;
      st = STAT_OK;
      if (pending_bytes == 0) begin
         if (len == 0) begin
            // empty record: trailer only, data byte dropped
            if (record_fits(0)) begin
               commit_record(0);
            end else begin
               st = STAT_FULL;
            end
         end else begin
            pending_len = len;
            if (len > RECORD_MAX || !record_fits(len)) begin
               st = STAT_FULL;
               // a longer refused record swallows its remaining bytes
               if (len > 1) begin
                  pending_rejected = 1'b1;
                  pending_bytes    = 1;
               end else begin
                  pending_len = 0;
               end
            end else begin
               store_mem[stack_top] = b;
               pending_bytes        = 1;
               pending_rejected     = 1'b0;
               if (pending_bytes >= pending_len) commit_record(pending_len);
            end
         end
      end else if (pending_rejected) begin
         st = STAT_FULL;
         pending_bytes++;
         if (pending_bytes >= pending_len) clear_pending();
      end else begin
         store_mem[stack_top + pending_bytes] = b;
         pending_bytes++;
         if (pending_bytes >= pending_len) commit_record(pending_len);
      end
      expected_rsps.push_back(make_rsp(st, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0));
   endfunction

   function automatic void predict_read(bit drop, int unsigned want);
      int unsigned stored, base, count;
      stored = 0;
      if (stack_top < TRAILER_BYTES) begin
         expected_rsps.push_back(make_rsp(STAT_EMPTY, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0));
         return;
      end
      for (int i = 0; i < TRAILER_BYTES; i++) begin
         stored |= 32'(store_mem[stack_top - TRAILER_BYTES + i]) << (8 * i);
      end
      // trailer clamped to the space below it, then to the record limit
      if (stored > stack_top - TRAILER_BYTES) stored = stack_top - TRAILER_BYTES;
      base = stack_top - TRAILER_BYTES - stored;
      if (stored > RECORD_MAX) stored = RECORD_MAX;
      count = (want < stored) ? want : stored;
      if (drop) stack_top = base;
      if (count == 0) begin
         expected_rsps.push_back(make_rsp(STAT_OK, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0));
      end else begin
         for (int i = 0; i < count; i++) begin
            expected_rsps.push_back(make_rsp(STAT_OK, store_mem[base + i], 1'b1,
                                             logic'(i + 1 == count), 1'b0, 1'b0));
         end
      end
   endfunction

   function automatic void predict_transaction(req_type r);
      int unsigned len;
      len = r.length;
      if (r.mode == MODE_PUSH) begin
         predict_push(r.data_byte, len);
      end else begin
         // any other transaction abandons a partly pushed record
         clear_pending();
         if (r.mode == MODE_QUERY) begin
            expected_rsps.push_back(make_rsp(STAT_OK, 8'h00, 1'b0, 1'b1,
                                             !record_fits(len), stack_top == 0));
         end else begin
            predict_read(r.mode == MODE_POP, len);
         end
      end
   endfunction

   function automatic string rsp_text(rsp_type r);
      return $sformatf("status=%0d byte=%02h valid=%b last=%b full=%b empty=%b",
                       r.status, r.out_byte, r.byte_valid, r.last,
                       r.would_be_full, r.is_empty);
   endfunction

   function automatic void note_mismatch(rsp_type exp, rsp_type got, bit orphan);
      if (mismatch_count < MAX_SHOWN) begin
         if (orphan) begin
            $display("%0t: response with nothing expected: %s", $realtime, rsp_text(got));
         end else begin
            $display("%0t: response mismatch: expected %s", $realtime, rsp_text(exp));
            $display("%0t:                         got %s", $realtime, rsp_text(got));
         end
      end
      mismatch_count++;
   endfunction

   function automatic void check_response(rsp_type got);
      rsp_type exp;
      if (expected_rsps.size() == 0) begin
         note_mismatch('0, got, 1'b1);
         return;
      end
      exp = expected_rsps.pop_front();
      if (got.status !== exp.status || got.out_byte !== exp.out_byte ||
          got.byte_valid !== exp.byte_valid || got.last !== exp.last ||
          got.would_be_full !== exp.would_be_full || got.is_empty !== exp.is_empty) begin
         note_mismatch(exp, got, 1'b0);
      end
   endfunction

   // Monitor: prediction first, so a transaction is queued before any of its
   // responses could show up. The watchdog counts edges where nothing moved.
   always @(posedge clock) begin
      if (!reset) begin
         if (start && busy === 1'b0) predict_transaction(req_item);
         if (rsp_valid === 1'b1) check_response(rsp_item);
         if ((start && busy === 1'b0) || rsp_valid === 1'b1) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Sender side
   // ---------------------------------------------------------------------

   // Drive one transaction and return at the edge that accepts it. A random
   // pause may first drop start; otherwise start stays high.
   task automatic send_item(input req_type item);
      if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      start    <= 1'b1;
      req_item <= item;
      do @(posedge clock); while (busy !== 1'b0);
   endtask

   // One whole record: length sampled on the first byte, the length field of
   // the remaining bytes is don't-care and gets random values.
   task automatic send_record(input int unsigned len);
      send_item(make_req(MODE_PUSH, 8'($urandom_range(255)), 7'(len)));
      for (int i = 1; i < len; i++) begin
         send_item(make_req(MODE_PUSH, 8'($urandom_range(255)), 7'($urandom_range(127))));
      end
   endtask

   // Hold off until every predicted response has come back. The extra edge
   // lets the monitor account for the last accepted transaction.
   task automatic wait_drained();
      start <= 1'b0;
      @(posedge clock);
      while (expected_rsps.size() != 0) @(posedge clock);
   endtask

   task automatic pop_until_empty();
      wait_drained();
      while (stack_top != 0) begin
         send_item(make_req(MODE_POP, 8'($urandom_range(255)), 7'($urandom_range(127))));
         wait_drained();
      end
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   task automatic test_empty_stack();
      send_item(make_req(MODE_PEEK, 8'hFF, 7'd64));
      send_item(make_req(MODE_POP, 8'h00, 7'd127));
      send_item(make_req(MODE_QUERY, 8'h00, 7'd0));
      send_item(make_req(MODE_QUERY, 8'hFF, 7'd64));
      // empty record, then popping it copies nothing
      send_item(make_req(MODE_PUSH, 8'hC3, 7'd0));
      send_item(make_req(MODE_QUERY, 8'h00, 7'd127));
      send_item(make_req(MODE_POP, 8'h00, 7'd64));
   endtask

   task automatic test_record_roundtrip();
      send_item(make_req(MODE_PUSH, 8'h00, 7'd3));
      send_item(make_req(MODE_PUSH, 8'hFF, 7'd127));
      send_item(make_req(MODE_PUSH, 8'hA5, 7'd0));
      send_item(make_req(MODE_PEEK, 8'h00, 7'd127));
      send_item(make_req(MODE_PEEK, 8'h00, 7'd0));
      send_item(make_req(MODE_PEEK, 8'h00, 7'd2));
      // single-byte record on top, read back whole and dropped by the pop
      send_item(make_req(MODE_PUSH, 8'h5A, 7'd1));
      send_item(make_req(MODE_POP, 8'h00, 7'd1));
      // record cut short by a pop: its bytes never commit
      send_item(make_req(MODE_PUSH, 8'h11, 7'd4));
      send_item(make_req(MODE_PUSH, 8'h22, 7'd4));
      send_item(make_req(MODE_POP, 8'h00, 7'd64));
   endtask

   task automatic test_push_rejection();
      // too long for any record: first and following bytes refused
      send_item(make_req(MODE_PUSH, 8'h01, 7'd65));
      send_item(make_req(MODE_PUSH, 8'h02, 7'd0));
      send_item(make_req(MODE_PEEK, 8'h00, 7'd64));
      send_item(make_req(MODE_PUSH, 8'h03, 7'd127));
      send_item(make_req(MODE_PUSH, 8'h04, 7'd5));
      send_item(make_req(MODE_QUERY, 8'h00, 7'd65));
   endtask

   // Whole records with random content half of the time; the rest is reads, queries,
   // records cut short and over-long records.
   task automatic run_random_traffic(input int items);
      int sent, pick, len, cut;
      sent = 0;
      while (sent < items) begin
         pick = $urandom_range(99);
         if (pick < 50) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(17, RECORD_MAX)
                                           : $urandom_range(0, 16);
            send_record(len);
            sent += (len == 0) ? 1 : len;
         end else if (pick < 60) begin
            len = ($urandom_range(2) == 0) ? $urandom_range(RECORD_MAX + 1, 127)
                                           : $urandom_range(2, 20);
            cut = $urandom_range(1, 5);
            send_item(make_req(MODE_PUSH, 8'($urandom_range(255)), 7'(len)));
            for (int i = 1; i < cut; i++) begin
               send_item(make_req(MODE_PUSH, 8'($urandom_range(255)),
                                  7'($urandom_range(127))));
            end
            send_item(make_req(2'($urandom_range(MODE_PEEK, MODE_QUERY)),
                               8'($urandom_range(255)), 7'($urandom_range(127))));
            sent += cut + 1;
         end else begin
            if (pick < 73)      send_item(make_req(MODE_PEEK, 8'($urandom_range(255)),
                                                   7'($urandom_range(127))));
            else if (pick < 90) send_item(make_req(MODE_POP, 8'($urandom_range(255)),
                                                   7'($urandom_range(127))));
            else                send_item(make_req(MODE_QUERY, 8'($urandom_range(255)),
                                                   7'($urandom_range(127))));
            sent++;
         end
      end
   endtask

   task automatic test_random_traffic();
      idle_pct = 0;
      run_random_traffic(30);
      // sender holds off until the block has answered everything
      wait_drained();
      idle_pct = 47;
      run_random_traffic(30);
      idle_pct = 13;
      run_random_traffic(30);
      idle_pct = 0;
   endtask

   // Pop every record left over, then check that the stack reports empty.
   task automatic test_unwind_to_empty();
      pop_until_empty();
      send_item(make_req(MODE_QUERY, 8'h00, 7'd0));
      send_item(make_req(MODE_PEEK, 8'h00, 7'd127));
   endtask

   initial begin
      stack_top = 0;
      clear_pending();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_empty_stack();
      test_record_roundtrip();
      test_push_rejection();
      test_random_traffic();
      test_unwind_to_empty();

      wait_drained();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

`default_nettype wire
